// ----- hw/rtl/apq_pkg.sv -----
// Shared types, constants and helpers for the attrition priority queue.
`timescale 1ns / 1ps

package apq_pkg;

    // Queue geometry
    localparam int DEPTH       = 64;
    localparam int VALUE_WIDTH = 32;
    localparam int PORT_WIDTH  = 32;

    typedef logic signed [VALUE_WIDTH-1:0] t_value;
    typedef logic signed [PORT_WIDTH-1:0]  t_port_value;

    // Request actions
    typedef enum logic [1:0] {
        ACT_INSERT = 2'd0,
        ACT_DELETE = 2'd1,
        ACT_PEEK   = 2'd2
    } t_action;

    // Result status codes
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    // Per-cycle command broadcast to every cell
    typedef enum logic [1:0] {
        CELL_HOLD   = 2'd0,
        CELL_INSERT = 2'd1,
        CELL_POP    = 2'd2
    } t_cell_op;

    typedef struct packed {
        t_cell_op op;
        t_value   value;
    } t_cell_cmd;

    // Sign-extend or truncate a port value to the stored width
    function automatic t_value widen_value(input t_port_value raw);
        logic signed [63:0] w;
        begin
            w = 64'(raw);
            return w[VALUE_WIDTH-1:0];
        end
    endfunction

    // Low port-width bits of a stored value, zero above the stored width
    function automatic t_port_value narrow_value(input t_value v);
        logic [63:0] z;
        begin
            z = '0;
            z[VALUE_WIDTH-1:0] = v;
            return z[PORT_WIDTH-1:0];
        end
    endfunction

endpackage

// ----- hw/rtl/apq_if.sv -----
// Request and result channel interfaces of the attrition priority queue.
`timescale 1ns / 1ps

interface apq_in_if
    import apq_pkg::*;
();
    logic                   valid;
    logic                   ready;
    logic [1:0]             action;
    logic signed [PORT_WIDTH-1:0] value;

    modport source (output valid, output action, output value, input ready);
    modport sink   (input valid, input action, input value, output ready);
endinterface

interface apq_out_if
    import apq_pkg::*;
();
    logic                   valid;
    logic                   ready;
    logic signed [PORT_WIDTH-1:0] min_value;
    logic [1:0]             status;
    logic                   now_empty;

    modport source (output valid, output min_value, output status, output now_empty,
                    input ready);
    modport sink   (input valid, input min_value, input status, input now_empty,
                    output ready);
endinterface

// ----- hw/rtl/attrition_priority_queue_unit.sv -----
// Top level of the attrition priority queue: request staging, cell chain, result register.
`timescale 1ns / 1ps

// Each request is first registered, then applied in a step in which every cell of the
// DEPTH-long chain compares its entry with the request in parallel and updates together with
// its neighbors. A new request is taken while the previous result still waits on the output;
// it is applied once that result has been taken. Insert discards all entries greater than or
// equal to the new value and appends it, unless every cell holds a smaller value (full);
// delete pops the minimum; peek reads it. The chain resets to empty.
module attrition_priority_queue_unit
    import apq_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    apq_in_if.sink    i_req,
    apq_out_if.source o_rsp
);

    logic        r_busy;
    logic        n_busy;
    logic [1:0]  r_action;
    t_value      r_value;
    logic        r_out_valid;
    logic        n_out_valid;
    t_port_value r_min_value;
    t_port_value n_min_value;
    t_status     r_status;
    t_status     n_status;
    logic        r_now_empty;
    logic        n_now_empty;

    logic        w_fire;
    t_cell_cmd   w_cmd;
    logic [DEPTH-1:0] w_valid;
    logic [DEPTH-1:0] w_kept;
    t_value      w_value [DEPTH];

    // Apply the staged request once the result register is free
    assign w_fire      = r_busy && (!r_out_valid || o_rsp.ready);
    assign i_req.ready = !r_busy;

    // Decode the staged request into a cell command and a result
    always_comb begin
        w_cmd.op    = CELL_HOLD;
        w_cmd.value = r_value;
        n_min_value = r_min_value;
        n_status    = r_status;
        n_now_empty = r_now_empty;
        n_out_valid = r_out_valid && !o_rsp.ready;
        n_busy      = r_busy;
        if (i_req.valid && i_req.ready) begin
            n_busy = 1'b1;
        end
        if (w_fire) begin
            n_busy      = 1'b0;
            n_out_valid = 1'b1;
            n_min_value = '0;
            n_status    = ST_OK;
            n_now_empty = !w_valid[0];
            case (r_action)
                ACT_INSERT: begin
                    n_now_empty = 1'b0;
                    if (w_kept[DEPTH-1]) begin
                        n_status = ST_FULL;
                    end else begin
                        w_cmd.op = CELL_INSERT;
                    end
                end
                ACT_DELETE: begin
                    if (w_valid[0]) begin
                        w_cmd.op    = CELL_POP;
                        n_min_value = narrow_value(w_value[0]);
                        n_now_empty = !w_valid[1];
                    end else begin
                        n_status = ST_EMPTY;
                    end
                end
                ACT_PEEK: begin
                    if (w_valid[0]) begin
                        n_min_value = narrow_value(w_value[0]);
                    end else begin
                        n_status = ST_EMPTY;
                    end
                end
                default: begin
                    n_status = ST_OK;
                end
            endcase
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_busy      <= n_busy;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (i_req.valid && i_req.ready) begin
            r_action <= i_req.action;
            r_value  <= widen_value(i_req.value);
        end
        r_min_value <= n_min_value;
        r_status    <= n_status;
        r_now_empty <= n_now_empty;
    end

    // Chain of cells, head at index 0
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic   w_prev_kept;
        logic   w_next_valid;
        t_value w_next_value;

        if (g == 0) begin : g_head
            assign w_prev_kept = 1'b1;
        end else begin : g_body
            assign w_prev_kept = w_kept[g-1];
        end

        if (g == DEPTH-1) begin : g_tail
            assign w_next_valid = 1'b0;
            assign w_next_value = '0;
        end else begin : g_link
            assign w_next_valid = w_valid[g+1];
            assign w_next_value = w_value[g+1];
        end

        apq_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_cmd        (w_cmd),
            .i_prev_kept  (w_prev_kept),
            .i_next_valid (w_next_valid),
            .i_next_value (w_next_value),
            .o_valid      (w_valid[g]),
            .o_value      (w_value[g]),
            .o_kept       (w_kept[g])
        );
    end

    assign o_rsp.valid     = r_out_valid;
    assign o_rsp.min_value = r_min_value;
    assign o_rsp.status    = r_status;
    assign o_rsp.now_empty = r_now_empty;

    // A successful insert leaves the head live
    a_insert_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cmd.op == CELL_INSERT) |=> w_valid[0])
        else $error("apq: insert left queue empty");

    // A pending result reflects the current chain occupancy
    a_empty_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_now_empty == !w_valid[0]))
        else $error("apq: empty flag disagrees with chain");

    // A full refusal only happens with every cell live
    a_full_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_status == ST_FULL)) |-> w_valid[DEPTH-1])
        else $error("apq: full status with free slot");

endmodule

// ----- hw/rtl/apq_cell.sv -----
// One slot of the sorted queue: holds a value and trades it with its neighbors.
`timescale 1ns / 1ps

module apq_cell
    import apq_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cell_cmd i_cmd,
    input  logic      i_prev_kept,
    input  logic      i_next_valid,
    input  t_value    i_next_value,
    output logic      o_valid,
    output t_value    o_value,
    output logic      o_kept
);

    logic   r_valid;
    logic   n_valid;
    t_value r_value;
    t_value n_value;

    // Survive an insert only when live and strictly below the new value
    assign o_kept = r_valid && (r_value < i_cmd.value);

    // Pick the next contents from the broadcast command
    always_comb begin
        n_valid = r_valid;
        n_value = r_value;
        case (i_cmd.op)
            CELL_INSERT: begin
                if (!o_kept) begin
                    n_valid = i_prev_kept;
                    n_value = i_cmd.value;
                end
            end
            CELL_POP: begin
                n_valid = i_next_valid;
                n_value = i_next_value;
            end
            default: begin
                n_valid = r_valid;
                n_value = r_value;
            end
        endcase
    end

    // Register the live flag, cleared under reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // Hold the value; no reset needed
    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

    assign o_valid = r_valid;
    assign o_value = r_value;

    // Live entries form a strictly ascending prefix
    a_ascending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_next_valid |-> (r_valid && (r_value < i_next_value)))
        else $error("apq_cell: entries out of order");

    // Kept cells form a prefix of the chain
    a_kept_prefix: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_kept |-> i_prev_kept)
        else $error("apq_cell: kept cell after a discarded one");

    // A pop takes over the neighbor's contents
    a_pop_shift: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.op == CELL_POP) |=> (r_valid == $past(i_next_valid)))
        else $error("apq_cell: pop did not shift");

endmodule
